/* rtl/core/fdre_pkg.sv */
// ----------------------------------------------------------------------------
// fdre_pkg
// shared types and constants of the frame delta run encoder
// ----------------------------------------------------------------------------
package fdre_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;   // pixels in one run
    localparam int LEN_W       = 9;   // encoded bytes of one run, up to 257
    localparam int CHUNK_BYTES = 8;
    localparam int SLOT_W      = 4;   // bytes held in a chunk, 0..8
    localparam int MAX_RUN_DEF = 255;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    // run kind codes
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_EQUAL   = 2'd1,
        KIND_UNEQUAL = 2'd2
    } run_kind_t;

    // leading byte of an encoded run
    localparam logic [BYTE_W-1:0] CODE_EQUAL   = 8'h00;
    localparam logic [BYTE_W-1:0] CODE_UNEQUAL = 8'h01;

endpackage

/* rtl/core/frame_delta_run_encoder_unit.sv */
// ----------------------------------------------------------------------------
// frame_delta_run_encoder_unit
// run length coder of pixel differences between two frames
// ----------------------------------------------------------------------------
// Each input word carries one pixel pair and an end-of-frame mark. Pixels
// are grouped into runs of equal or unequal pairs of at most MAX_RUN pixels;
// a closed equal run is sent as 0x00 and its length, an unequal run as 0x01,
// its length and the low byte of current minus previous for every pixel.
// The encoded bytes leave in output words of up to eight bytes, never mixing
// two runs, with tlast on the last word of the run closed by the frame end.
// A pixel that leaves its run open is taken without a stall. Once a run
// closes the input stalls while a single byte placement path builds the
// output words: each encoded byte passes a fetch and a place state (the
// delta store is read one entry a cycle with registered data), each output
// word a push state, held while the output side holds off. A pixel of the
// other kind first closes the previous run, and may close its own run straight after.
// ----------------------------------------------------------------------------
module frame_delta_run_encoder_unit
    import fdre_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // current_pixel [7:0], previous_pixel [15:8]
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,     // frame_end
    // out_byte0 [7:0] .. out_byte7 [63:56], byte_count [67:64], zero [71:68]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast      // frame_done
);

    localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam logic [COUNT_W-1:0] RUN_LIMIT = COUNT_W'(MAX_RUN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PLACE,
        ST_PUSH
    } state_t;

    state_t                         state_reg;
    run_kind_t                      run_kind_reg;
    logic [COUNT_W-1:0]             run_count_reg;
    // run being sent
    run_kind_t                      em_kind_reg;
    logic [COUNT_W-1:0]             em_cnt_reg;
    logic                           em_last_reg;
    // open run must be sent as well once the current one is out
    logic                           pend_close_reg;
    logic                           pend_end_reg;
    logic [LEN_W-1:0]               pos_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [BYTE_W-1:0]              chunk_reg [CHUNK_BYTES];
    logic                           out_valid_reg;
    logic [CHUNK_BYTES*BYTE_W-1:0]  out_bytes_reg;
    logic [SLOT_W-1:0]              out_count_reg;
    logic                           out_last_reg;

    logic [BYTE_W-1:0]              cur_pixel;
    logic [BYTE_W-1:0]              prev_pixel;
    run_kind_t                      new_kind;
    logic                           accept;
    logic                           change;
    logic [COUNT_W-1:0]             base;
    logic [COUNT_W-1:0]             cnt1;
    logic                           close_now;
    logic [LEN_W-1:0]               total;
    logic [LEN_W-1:0]               pos_inc;
    logic [LEN_W-1:0]               rd_idx;
    logic                           done;
    logic                           push_ok;
    logic                           push_fire;
    logic [BYTE_W-1:0]              byte_sel;
    logic [BYTE_W-1:0]              rd_data;
    logic [CHUNK_BYTES*BYTE_W-1:0]  chunk_flat;

    assign cur_pixel  = s_axis_tdata[BYTE_W-1:0];
    assign prev_pixel = s_axis_tdata[2*BYTE_W-1:BYTE_W];
    assign new_kind   = (cur_pixel == prev_pixel) ? KIND_EQUAL : KIND_UNEQUAL;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // a pixel of the other kind starts afresh at count zero
    assign change    = (run_kind_reg != KIND_NONE) && (run_kind_reg != new_kind);
    assign base      = (run_kind_reg == new_kind) ? run_count_reg : '0;
    assign cnt1      = base + COUNT_W'(1);
    assign close_now = s_axis_tlast || (cnt1 >= RUN_LIMIT);

    // encoded length of the run being sent
    assign total   = (em_kind_reg == KIND_UNEQUAL) ? (LEN_W'(2) + LEN_W'(em_cnt_reg))
                                                   : LEN_W'(2);
    assign pos_inc = pos_reg + LEN_W'(1);
    assign rd_idx  = pos_reg - LEN_W'(2);
    assign done    = (pos_reg == total);
    assign push_ok = !out_valid_reg || m_axis_tready;

    // a new word enters the output register this cycle
    assign push_fire = (state_reg == ST_PUSH) && push_ok;

    // header bytes first, then deltas
    always_comb
    begin
        if (pos_reg == LEN_W'(0))
        begin
            byte_sel = (em_kind_reg == KIND_EQUAL) ? CODE_EQUAL : CODE_UNEQUAL;
        end
        else if (pos_reg == LEN_W'(1))
        begin
            byte_sel = em_cnt_reg;
        end
        else
        begin
            byte_sel = rd_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            chunk_flat[i*BYTE_W +: BYTE_W] = chunk_reg[i];
        end
    end

    fdre_delta_ram #(
        .DEPTH  (MAX_RUN),
        .ADDR_W (ADDR_W)
    ) u_delta_ram (
        .clk     (clk),
        .wr_en   (accept && (new_kind == KIND_UNEQUAL)),
        .wr_addr (base[ADDR_W-1:0]),
        .wr_data (cur_pixel - prev_pixel),
        .rd_en   (state_reg == ST_FETCH),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_kind_reg   <= KIND_NONE;
            run_count_reg  <= '0;
            em_kind_reg    <= KIND_NONE;
            em_cnt_reg     <= '0;
            em_last_reg    <= 1'b0;
            pend_close_reg <= 1'b0;
            pend_end_reg   <= 1'b0;
            pos_reg        <= '0;
            slot_reg       <= '0;
            for (int i = 0; i < CHUNK_BYTES; i++)
            begin
                chunk_reg[i] <= '0;
            end
            out_valid_reg  <= 1'b0;
            out_bytes_reg  <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !push_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg  <= '0;
                        slot_reg <= '0;
                        for (int i = 0; i < CHUNK_BYTES; i++)
                        begin
                            chunk_reg[i] <= '0;
                        end
                        if (change)
                        begin
                            // send the old run, keep the new one open
                            em_kind_reg    <= run_kind_reg;
                            em_cnt_reg     <= run_count_reg;
                            em_last_reg    <= 1'b0;
                            run_kind_reg   <= new_kind;
                            run_count_reg  <= cnt1;
                            pend_close_reg <= close_now;
                            pend_end_reg   <= s_axis_tlast;
                            state_reg      <= ST_FETCH;
                        end
                        else if (close_now)
                        begin
                            em_kind_reg    <= new_kind;
                            em_cnt_reg     <= cnt1;
                            em_last_reg    <= s_axis_tlast;
                            run_kind_reg   <= KIND_NONE;
                            run_count_reg  <= '0;
                            pend_close_reg <= 1'b0;
                            state_reg      <= ST_FETCH;
                        end
                        else
                        begin
                            run_kind_reg  <= new_kind;
                            run_count_reg <= cnt1;
                        end
                    end
                end

                ST_FETCH:
                begin
                    // delta read issued here, data ready next cycle
                    state_reg <= ST_PLACE;
                end

                ST_PLACE:
                begin
                    chunk_reg[slot_reg[SLOT_W-2:0]] <= byte_sel;
                    slot_reg <= slot_reg + SLOT_W'(1);
                    pos_reg  <= pos_inc;
                    if ((pos_inc == total) || (slot_reg == SLOT_W'(CHUNK_BYTES - 1)))
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        state_reg <= ST_FETCH;
                    end
                end

                ST_PUSH:
                begin
                    if (push_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bytes_reg <= chunk_flat;
                        out_count_reg <= slot_reg;
                        out_last_reg  <= em_last_reg && done;
                        slot_reg      <= '0;
                        for (int i = 0; i < CHUNK_BYTES; i++)
                        begin
                            chunk_reg[i] <= '0;
                        end
                        if (!done)
                        begin
                            state_reg <= ST_FETCH;
                        end
                        else if (pend_close_reg)
                        begin
                            // run opened by the kind change closes too
                            em_kind_reg    <= run_kind_reg;
                            em_cnt_reg     <= run_count_reg;
                            em_last_reg    <= pend_end_reg;
                            run_kind_reg   <= KIND_NONE;
                            run_count_reg  <= '0;
                            pend_close_reg <= 1'b0;
                            pos_reg        <= '0;
                            state_reg      <= ST_FETCH;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_count_reg, out_bytes_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/core/fdre_delta_ram.sv */
// ----------------------------------------------------------------------------
// fdre_delta_ram
// delta store of the open run, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fdre_delta_ram
    import fdre_pkg::*;
#(
    parameter int DEPTH  = MAX_RUN_DEF,
    parameter int ADDR_W = 8
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/run_code_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_code_checker
// predicts the encoded output words from the accepted pixels and checks them
// ----------------------------------------------------------------------------
module run_code_checker
    import fdre_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     errors,
    output int                     pending,
    output int                     words_checked
);

    localparam int COUNT_LSB = CHUNK_BYTES * BYTE_W;
    localparam int PAD_LSB   = COUNT_LSB + SLOT_W;

    typedef struct packed {
        logic                                done;
        logic [SLOT_W-1:0]                   count;
        logic [CHUNK_BYTES-1:0][BYTE_W-1:0]  bytes;
    } chunk_t;

    run_kind_t         open_kind;
    logic [COUNT_W-1:0] open_count;
    logic [BYTE_W-1:0] delta_mem [0:MAX_RUN_DEF-1];
    chunk_t            expected_chunks [$];

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        if (errors < 50)
            $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
        errors++;
    endtask

    // split the open run into output words and queue them
    task automatic flush_run(input logic frame_last);
        logic [BYTE_W-1:0] enc [0:MAX_RUN_DEF+1];
        int     n;
        int     pos;
        int     take;
        int     j;
        chunk_t c;
        if (open_kind == KIND_NONE)
            return;
        enc[0] = (open_kind == KIND_EQUAL) ? CODE_EQUAL : CODE_UNEQUAL;
        enc[1] = open_count;
        n = 2;
        if (open_kind == KIND_UNEQUAL)
        begin
            for (j = 0; j < int'(open_count); j++)
            begin
                enc[n] = delta_mem[j];
                n++;
            end
        end
        for (pos = 0; pos < n; pos += CHUNK_BYTES)
        begin
            take = (n - pos > CHUNK_BYTES) ? CHUNK_BYTES : n - pos;
            c = '0;
            for (j = 0; j < take; j++)
                c.bytes[j] = enc[pos + j];
            c.count = SLOT_W'(take);
            c.done  = frame_last && (pos + take >= n);
            expected_chunks.push_back(c);
        end
        open_kind  = KIND_NONE;
        open_count = '0;
    endtask

    task automatic encode_pixel(input logic [BYTE_W-1:0] cur, input logic [BYTE_W-1:0] prev,
                                input logic frame_end);
        run_kind_t kind;
        kind = (cur == prev) ? KIND_EQUAL : KIND_UNEQUAL;
        // a pixel of the other kind closes the open run first
        if (open_kind != KIND_NONE && open_kind != kind)
            flush_run(1'b0);
        if (open_kind == KIND_NONE)
        begin
            open_kind  = kind;
            open_count = '0;
        end
        if (kind == KIND_UNEQUAL && open_count < COUNT_W'(MAX_RUN_DEF))
            delta_mem[open_count] = cur - prev;
        open_count = open_count + 1'b1;
        if (frame_end || int'(open_count) >= MAX_RUN)
            flush_run(frame_end);
    endtask

    task automatic compare_word(input logic [OUT_TDATA_W-1:0] data, input logic last);
        chunk_t want;
        int     j;
        if (expected_chunks.size() == 0)
        begin
            report_mismatch("unexpected output word", '0, data[15:0]);
            return;
        end
        want = expected_chunks.pop_front();
        for (j = 0; j < CHUNK_BYTES; j++)
            if (data[j*BYTE_W +: BYTE_W] !== want.bytes[j])
                report_mismatch($sformatf("out_byte%0d", j), 16'(want.bytes[j]),
                                16'(data[j*BYTE_W +: BYTE_W]));
        if (data[COUNT_LSB +: SLOT_W] !== want.count)
            report_mismatch("byte_count", 16'(want.count), 16'(data[COUNT_LSB +: SLOT_W]));
        if (data[OUT_TDATA_W-1:PAD_LSB] !== '0)
            report_mismatch("tdata padding", '0, 16'(data[OUT_TDATA_W-1:PAD_LSB]));
        if (last !== want.done)
            report_mismatch("frame_done", 16'(want.done), 16'(last));
        words_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_kind  = KIND_NONE;
            open_count = '0;
            expected_chunks.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                encode_pixel(s_axis_tdata[BYTE_W-1:0], s_axis_tdata[2*BYTE_W-1:BYTE_W],
                             s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                compare_word(m_axis_tdata, m_axis_tlast);
        end
        pending = expected_chunks.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the frame delta run encoder
// ----------------------------------------------------------------------------
// Feeds pixel pairs as frames built from runs of equal and unequal pairs,
// first a short directed set, then random frames under four idle patterns
// on the input and output streams. A separate checker predicts every output
// word and compares it; this module only drives and decides the outcome.
// ----------------------------------------------------------------------------
module tb;
    import fdre_pkg::*;

    localparam int RUN_CAP = MAX_RUN_DEF;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // current_pixel [7:0], previous_pixel [15:8]
    logic                   s_axis_tlast  = 1'b0;  // frame_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // out_byte0..7 [63:0], byte_count [67:64]
    logic                   m_axis_tlast;          // frame_done

    int errors;
    int pending;
    int words_checked;

    // traffic shaping, percentages out of a hundred
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long output hold-off, handed to the receiver process
    int hold_request = 0;
    int hold_left = 0;

    int pixels_sent = 0;
    int frame_count = 0;

    frame_delta_run_encoder_unit #(
        .MAX_RUN (RUN_CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    run_code_checker #(
        .MAX_RUN (RUN_CAP)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // hard stop in case the block locks up
    initial
    begin
        #3_000_000;
        $display("timeout with %0d output words still outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // one pixel pair, with random idle cycles in front; returns once accepted
    task automatic send_pixel(input logic [7:0] cur, input logic [7:0] prev, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prev, cur};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
        if (last)
            frame_count++;
    endtask

    // a run of one kind with random content; optionally ends the frame
    task automatic send_run(input logic equal, input int len, input logic close_frame);
        int         i;
        logic [7:0] cur;
        logic [7:0] prev;
        for (i = 0; i < len; i++)
        begin
            cur  = 8'($urandom_range(0, 255));
            prev = equal ? cur : cur ^ 8'($urandom_range(1, 255));
            send_pixel(cur, prev, close_frame && (i == len - 1));
        end
    endtask

    // well-formed frame: a few runs, mostly short, now and then longer
    task automatic random_frame();
        int runs;
        int r;
        int len;
        runs = $urandom_range(1, 6);
        for (r = 0; r < runs; r++)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            send_run(1'($urandom_range(0, 1)), len, r == runs - 1);
        end
    endtask

    // noise frame: pairs drawn independently, equal now and then
    task automatic noise_frame();
        int         len;
        int         i;
        logic [7:0] cur;
        logic [7:0] prev;
        len = $urandom_range(1, 20);
        for (i = 0; i < len; i++)
        begin
            cur  = 8'($urandom_range(0, 255));
            prev = ($urandom_range(0, 3) == 0) ? cur : 8'($urandom_range(0, 255));
            send_pixel(cur, prev, i == len - 1);
        end
    endtask

    // sender goes quiet until the checker holds no expectation
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int quota);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = pixels_sent + quota;
        while (pixels_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
                noise_frame();
            else
                random_frame();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-pixel frames at the byte extremes
        send_pixel(8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'hFF, 1'b1);   // delta wraps to 0x01
        send_pixel(8'hFF, 8'h00, 1'b1);   // delta 0xff
        // kind change and frame end on the same pixel: two runs in one go
        send_pixel(8'h80, 8'h7F, 1'b0);
        send_pixel(8'h7F, 8'h80, 1'b0);
        send_pixel(8'h55, 8'h55, 1'b1);
        // equal run closed by an unequal run that fills exactly one word
        send_run(1'b1, 3, 1'b0);
        send_run(1'b0, 6, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b1);
        // unequal run one byte over a word
        send_run(1'b0, 7, 1'b1);

        // free flow: an unequal run filling the whole delta store up to the cap,
        // then a one-pixel run that ends the frame
        send_run(1'b0, RUN_CAP + 1, 1'b1);
        random_phase(0, 0, 40);

        // sparse input, with a full drain half way
        random_phase(85, 0, 25);
        wait_drained();
        random_phase(85, 0, 25);

        // output held off for a long stretch while pixels keep coming
        send_idle_pct = 0;
        hold_request  = 400;
        random_frame();
        random_frame();
        random_phase(0, 85, 40);

        // both sides throttled
        random_phase(38, 38, 40);

        // finish on a frame end so no run stays open
        send_pixel(8'h3C, 8'hC3, 1'b1);
        wait_drained();
        repeat (100) @(posedge clk);

        $display("sent %0d pixel pairs in %0d frames, checked %0d output words",
                 pixels_sent, frame_count, words_checked);
        $display("covered free flow, sparse input, held and stalled output, runs up to %0d",
                 RUN_CAP);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fdre_pkg.sv
rtl/core/fdre_delta_ram.sv
rtl/core/frame_delta_run_encoder_unit.sv
tb/run_code_checker.sv
tb/tb.sv
